>>> rtl/core/mrpt_pkg.sv
// Package for the 64-bit Miller-Rabin prime tester.
// Holds the witness table, sequencer states and multiplier control struct.
// No dependencies.
`default_nettype none
package mrpt_pkg;
  localparam int W = 64;
  localparam int NWIT = 12;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIAL, ST_SPLIT, ST_WSTART, ST_EXP_BIT, ST_EXP_MUL,
    ST_EXP_SQ, ST_WCHECK, ST_SQLOOP, ST_SQWAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic         start;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] m;
  } mul_req_t;

  function automatic logic [5:0] witness(input logic [3:0] idx);
    case (idx)
      4'd0: witness = 6'd2;
      4'd1: witness = 6'd3;
      4'd2: witness = 6'd5;
      4'd3: witness = 6'd7;
      4'd4: witness = 6'd11;
      4'd5: witness = 6'd13;
      4'd6: witness = 6'd17;
      4'd7: witness = 6'd19;
      4'd8: witness = 6'd23;
      4'd9: witness = 6'd29;
      4'd10: witness = 6'd31;
      4'd11: witness = 6'd37;
      default: witness = 6'd2;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/mrpt_modmul.sv
// Bit-serial modular multiplier: one bit of y per cycle, double and add mod m.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_modmul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mrpt_pkg::mul_req_t req,
  output logic                    busy,
  output logic [63:0]             result
);
  import mrpt_pkg::*;
  logic [W-1:0] acc_r, acc_nxt, x_r, y_r, m_r;
  logic [6:0]   cnt_r;
  logic         busy_r;
  logic [W:0]   dbl, dadd;
  logic [W-1:0] a1;

  always_comb begin
    dbl = {acc_r, 1'b0};
    a1 = (dbl >= {1'b0, m_r}) ? W'(dbl - {1'b0, m_r}) : dbl[W-1:0];
    dadd = {1'b0, a1} + {1'b0, x_r};
    acc_nxt = a1;
    if (y_r[W-1])
      acc_nxt = (dadd >= {1'b0, m_r}) ? W'(dadd - {1'b0, m_r}) : dadd[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'(W);
      acc_r  <= '0;
      x_r    <= req.x;
      y_r    <= req.y;
      m_r    <= req.m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[W-2:0], 1'b0};
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign result = acc_r;
endmodule
`default_nettype wire

>>> rtl/core/mrpt_trial.sv
// Bit-serial remainder of the candidate by the twelve small primes, in parallel.
// Depends on mrpt_pkg.
`default_nettype none
module mrpt_trial (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] n,
  output logic             busy,
  output logic [11:0]      divisible
);
  import mrpt_pkg::*;
  logic [5:0]   rem_r [NWIT];
  logic [W-1:0] sh_r;
  logic [6:0]   cnt_r;
  logic         busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'(W);
      sh_r   <= n;
      for (int i = 0; i < NWIT; i++) rem_r[i] <= '0;
    end else if (busy_r) begin
      for (int i = 0; i < NWIT; i++) begin
        logic [6:0] t;
        t = {rem_r[i], sh_r[W-1]};
        rem_r[i] <= (t >= {1'b0, witness(4'(i))}) ? 6'(t - {1'b0, witness(4'(i))}) : t[5:0];
      end
      sh_r  <= {sh_r[W-2:0], 1'b0};
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  always_comb
    for (int i = 0; i < NWIT; i++) divisible[i] = (rem_r[i] == 6'd0);
  assign busy = busy_r;
endmodule
`default_nettype wire

>>> rtl/core/miller_rabin_prime_test_64.sv
// Top level of the 64-bit deterministic Miller-Rabin prime tester.
// Depends on mrpt_pkg, mrpt_trial and mrpt_modmul.
// Usage:
//   in_tdata[63:0] carries one candidate per request, accepted when
//   in_tvalid and in_tready are high. in_tready is high only while idle.
//   out_tdata[0] carries prime_flag; the result is held until out_tready.
//   Steps: trial division by the twelve small primes, splitting of n-1,
//   then up to twelve rounds of up to 128 modular multiplications each
//   on the one shared bit-serial multiplier. Small or composite inputs
//   usually finish far sooner than the worst case.
//   One candidate is in flight at a time; the multiplier loop sets rate.
//   Reset returns the sequencer to idle with no result pending.
//   A stalled receiver holds the result and keeps in_tready low.
//   No memories, no clearing pass.
`default_nettype none
module miller_rabin_prime_test_64 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // candidate[63:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // prime_flag[0], zeros above
);
  import mrpt_pkg::*;

  state_t       state_r, state_nxt;
  logic [W-1:0] n_r, d_r, e_r, res_r, b_r, x_r;
  logic [5:0]   s_r, i_r;
  logic [3:0]   w_r;
  logic         flag_r, ovalid_r, first_r;
  logic         trial_start, trial_busy, mul_busy;
  logic [11:0]  divisible;
  logic         small_hit;
  logic [W-1:0] mul_res, nm1;
  mul_req_t     mreq;

  mrpt_trial u_trial (.clk, .rst_n, .start(trial_start), .n(in_tdata),
                      .busy(trial_busy), .divisible);
  mrpt_modmul u_mul (.clk, .rst_n, .req(mreq), .busy(mul_busy), .result(mul_res));

  assign nm1 = n_r - 64'd1;
  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;
  assign trial_start = (state_r == ST_IDLE) && in_tvalid && in_tready;

  always_comb begin
    small_hit = 1'b0;
    for (int k = 0; k < NWIT; k++)
      small_hit = small_hit | (divisible[k] && (n_r == 64'(witness(4'(k)))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mreq = '{start: 1'b0, x: res_r, y: b_r, m: n_r};
    unique case (state_r)
      ST_IDLE:  if (trial_start) state_nxt = ST_TRIAL;
      ST_TRIAL: if (!trial_busy && !first_r)
        state_nxt = (n_r < 64'd2 || divisible != '0) ? ST_DONE : ST_SPLIT;
      ST_SPLIT: if (d_r[0]) state_nxt = ST_WSTART;
      ST_WSTART: state_nxt = ST_EXP_BIT;
      ST_EXP_BIT: begin
        if (e_r == '0) state_nxt = ST_WCHECK;
        else if (e_r[0]) begin
          mreq.start = 1'b1;
          state_nxt = ST_EXP_MUL;
        end else begin
          mreq = '{start: 1'b1, x: b_r, y: b_r, m: n_r};
          state_nxt = ST_EXP_SQ;
        end
      end
      ST_EXP_MUL: if (!mul_busy && !first_r) begin
        mreq = '{start: 1'b1, x: b_r, y: b_r, m: n_r};
        state_nxt = ST_EXP_SQ;
      end
      ST_EXP_SQ: if (!mul_busy && !first_r) state_nxt = ST_EXP_BIT;
      ST_WCHECK, ST_SQLOOP: begin
        if (x_r == nm1 || (state_r == ST_WCHECK && x_r == 64'd1)) begin
          state_nxt = (w_r == 4'(NWIT - 1)) ? ST_DONE : ST_WSTART;
        end else if (i_r >= s_r) state_nxt = ST_DONE;
        else begin
          mreq = '{start: 1'b1, x: x_r, y: x_r, m: n_r};
          state_nxt = ST_SQWAIT;
        end
      end
      ST_SQWAIT: if (!mul_busy && !first_r) state_nxt = ST_SQLOOP;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      first_r <= mreq.start || trial_start;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (trial_start) n_r <= in_tdata;
        ST_TRIAL: if (!trial_busy && !first_r) begin
          d_r <= nm1;
          s_r <= '0;
          w_r <= 4'd15;
          if (n_r < 64'd2) flag_r <= 1'b0;
          else if (divisible != '0) flag_r <= small_hit;
          else flag_r <= 1'b1;
        end
        ST_SPLIT: if (!d_r[0]) begin
          d_r <= {1'b0, d_r[W-1:1]};
          s_r <= s_r + 6'd1;
        end
        ST_WSTART: begin
          w_r   <= w_r + 4'd1;
          e_r   <= d_r;
          res_r <= 64'd1;
          b_r   <= 64'(witness(w_r + 4'd1));
          i_r   <= 6'd1;
        end
        ST_EXP_BIT: if (e_r == '0) x_r <= res_r;
        ST_EXP_MUL: if (!mul_busy && !first_r) res_r <= mul_res;
        ST_EXP_SQ: if (!mul_busy && !first_r) begin
          b_r <= mul_res;
          e_r <= {1'b0, e_r[W-1:1]};
        end
        ST_WCHECK, ST_SQLOOP:
          if (!(x_r == nm1 || (state_r == ST_WCHECK && x_r == 64'd1)) && i_r >= s_r)
            flag_r <= 1'b0;
        ST_SQWAIT: if (!mul_busy && !first_r) begin
          x_r <= mul_res;
          i_r <= i_r + 6'd1;
        end
        ST_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, flag_r};

  property p_hold;
    @(posedge clk) disable iff (!rst_n) out_tvalid && !out_tready |=> out_tvalid;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mul_busy) else $error("multiplier restarted while busy");
endmodule
`default_nettype wire

>>> test/miller_rabin_prime_test_64_checker.sv
// Checker for the 64-bit Miller-Rabin prime tester: watches both streams,
// computes the expected prime flag per request and compares each result.
// Depends on nothing but the block's port widths.
module miller_rabin_prime_test_64_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  output int               fail_count,
  output int               pending
);
  localparam logic [5:0] SMALL_PRIMES [12] = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
                                              6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

  logic [7:0] expected_flags [$];

  function automatic logic [63:0] mulmod_64(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod_64(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq = b % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mulmod_64(acc, sq, m);
      sq = mulmod_64(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic is_prime_64(logic [63:0] n);
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] x;
    int s;
    logic passed;
    if (n < 64'd2) return 1'b0;
    foreach (SMALL_PRIMES[w])
      if (n % 64'(SMALL_PRIMES[w]) == 64'd0) return n == 64'(SMALL_PRIMES[w]);
    nm1 = n - 64'd1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (SMALL_PRIMES[w]) begin
      x = powmod_64(64'(SMALL_PRIMES[w]), d, n);
      if (x == 64'd1 || x == nm1) continue;
      passed = 1'b0;
      for (int i = 1; i < s; i++) begin
        x = mulmod_64(x, x, n);
        if (x == nm1) begin
          passed = 1'b1;
          break;
        end
      end
      if (!passed) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("error: %s got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_flags.push_back({7'd0, is_prime_64(in_tdata)});
      if (out_tvalid && out_tready) begin
        if (expected_flags.size() == 0) report("unexpected result", out_tdata, 8'd0);
        else if (out_tdata != expected_flags[0])
          report("prime_flag", out_tdata, expected_flags.pop_front());
        else void'(expected_flags.pop_front());
      end
      pending <= expected_flags.size();
    end
  end
endmodule

>>> test/miller_rabin_prime_test_64_test.sv
// Testbench top for the 64-bit Miller-Rabin prime tester: drives candidates
// with random gaps and stalls, gives the verdict from the checker's count.
// Depends on miller_rabin_prime_test_64 and miller_rabin_prime_test_64_checker.
module miller_rabin_prime_test_64_test;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  int          fail_count;
  int          pending;

  miller_rabin_prime_test_64 dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  miller_rabin_prime_test_64_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  localparam logic [63:0] DIRECTED [20] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd39, 64'd41, 64'd561, 64'd2047,
    64'd1763, 64'd3215031751, 64'd1000000007, 64'h1fffffffffffffff,
    64'hffffffffffffffc5, 64'hffffffffffffffff, 64'hfffffffffffffffe,
    64'h8000000000000000, 64'd18446743979220271189, 64'd9223372036854775783
  };

  always #4 clk = ~clk;

  task automatic send_request(logic [63:0] cand);
    logic ready_seen;
    repeat ($urandom_range(0, 3)) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = cand;
    forever begin
      ready_seen = in_tready;
      @(posedge clk);
      if (ready_seen) break;
      @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata = {$urandom, $urandom};
  endtask

  initial begin
    logic valid_seen;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
      out_tready = 1'b1;
      forever begin
        valid_seen = out_tvalid;
        @(posedge clk);
        if (valid_seen) break;
        @(negedge clk);
      end
    end
  end

  initial begin
    #400000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [63:0] cand;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 64'd0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    foreach (DIRECTED[i]) send_request(DIRECTED[i]);
    for (int i = 0; i < 120; i++) begin
      case ($urandom_range(0, 4))
        0: cand = 64'($urandom_range(0, 100000));
        1: cand = {32'd0, $urandom} | 64'd1;
        2: cand = {$urandom, $urandom} | 64'd1;
        default: cand = {$urandom, $urandom};
      endcase
      send_request(cand);
    end
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
